[design/phrc_pkg.sv]
// ----------------------------------------------------------------------------
// phrc_pkg: shared types for the pose history ring
// Command codes and the per-word result flags passed from control to datapath.
// ----------------------------------------------------------------------------
package phrc_pkg;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_PREV  = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic moved;
    logic pose_valid;
    logic from_add;
  } res_t;

endpackage

[design/phrc_if.sv]
// ----------------------------------------------------------------------------
// phrc_in_if / phrc_out_if: valid/ready channels of the pose history ring
// A word moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface phrc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_bearing;

  modport source (output valid, mode, pose_x, pose_y, pose_bearing, input ready);
  modport sink   (input valid, mode, pose_x, pose_y, pose_bearing, output ready);
endinterface

interface phrc_out_if;
  logic               valid;
  logic               ready;
  logic               moved;
  logic               pose_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_bearing;

  modport source (output valid, moved, pose_valid, out_x, out_y, out_bearing, input ready);
  modport sink   (input valid, moved, pose_valid, out_x, out_y, out_bearing, output ready);
endinterface

[design/phrc_ram.sv]
// ----------------------------------------------------------------------------
// phrc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module phrc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/phrc_ctrl.sv]
// ----------------------------------------------------------------------------
// phrc_ctrl: ring pointers and cursor control
// Tracks write slot, cursor and fill count; decides moves and RAM addresses.
// ----------------------------------------------------------------------------
module phrc_ctrl #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  phrc_pkg::mode_e          mode_i,
  output logic                     we_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [$clog2(DEPTH)-1:0] raddr_o,
  output phrc_pkg::res_t           res_o
);
  import phrc_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [SUM_W-1:0]  DepthS   = SUM_W'(DEPTH);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(DEPTH);

  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [SUM_W-1:0]  oldest_sum, oldest_wrap, pos_sum, pos_wrap;
  logic [SLOT_W-1:0] oldest, pos, cursor_dec, cursor_inc, write_inc;
  logic              is_empty, at_oldest, at_newest;

  always_comb begin
    oldest_sum  = SUM_W'(write_slot_q) + (DepthS - SUM_W'(count_q));
    oldest_wrap = (oldest_sum >= DepthS) ? oldest_sum - DepthS : oldest_sum;
    oldest      = oldest_wrap[SLOT_W-1:0];
    pos_sum     = SUM_W'(cursor_q) + DepthS - SUM_W'(oldest);
    pos_wrap    = (pos_sum >= DepthS) ? pos_sum - DepthS : pos_sum;
    pos         = pos_wrap[SLOT_W-1:0];

    is_empty  = (count_q == '0);
    at_oldest = (pos == '0);
    at_newest = ((SUM_W'(pos) + SUM_W'(1)) >= SUM_W'(count_q));

    cursor_dec = (cursor_q == '0) ? LastSlot : cursor_q - SLOT_W'(1);
    cursor_inc = (cursor_q == LastSlot) ? '0 : cursor_q + SLOT_W'(1);
    write_inc  = (write_slot_q == LastSlot) ? '0 : write_slot_q + SLOT_W'(1);

    write_slot_d = write_slot_q;
    cursor_d     = cursor_q;
    count_d      = count_q;
    res_o        = '{moved: 1'b0, pose_valid: 1'b0, from_add: 1'b0};

    case (mode_i)
      MODE_ADD: begin
        cursor_d     = write_slot_q;
        write_slot_d = write_inc;
        count_d      = (count_q == FullCnt) ? count_q : count_q + CNT_W'(1);
        res_o        = '{moved: 1'b1, pose_valid: 1'b1, from_add: 1'b1};
      end
      MODE_CLEAR: begin
        cursor_d     = '0;
        write_slot_d = '0;
        count_d      = '0;
        res_o        = '{moved: 1'b1, pose_valid: 1'b0, from_add: 1'b0};
      end
      MODE_PREV: begin
        if (!is_empty) begin
          res_o.pose_valid = 1'b1;
          if (!at_oldest) begin
            cursor_d    = cursor_dec;
            res_o.moved = 1'b1;
          end
        end
      end
      MODE_NEXT: begin
        if (!is_empty) begin
          res_o.pose_valid = 1'b1;
          if (!at_newest) begin
            cursor_d    = cursor_inc;
            res_o.moved = 1'b1;
          end
        end
      end
      default: begin
        res_o = '{moved: 1'b0, pose_valid: 1'b0, from_add: 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_slot_q <= '0;
      cursor_q     <= '0;
      count_q      <= '0;
    end else if (accept_i) begin
      write_slot_q <= write_slot_d;
      cursor_q     <= cursor_d;
      count_q      <= count_d;
    end
  end

  assign we_o    = accept_i && (mode_i == MODE_ADD);
  assign waddr_o = write_slot_q;
  assign raddr_o = cursor_d;

endmodule

[design/pose_history_ring_cursor_core.sv]
// ----------------------------------------------------------------------------
// pose_history_ring_cursor_core: pose history ring with a cursor
// Stores the last DEPTH poses and steps a cursor over them.
//
//   channel | dir | words                                   | handshake
//   in_i    | in  | mode, pose_x, pose_y, pose_bearing      | valid/ready
//   out_o   | out | moved, pose_valid, out_x/y/bearing      | valid/ready
//
// One command per cycle while out_o is not stalled; its result word appears in the cycle after accept.
// Pointer update, RAM write and RAM read all happen on the accept edge;
// the RAM's registered read port holds the pose read for the result word.
// in_i.ready drops only while a result word is stalled on out_o.
// Reset empties the history; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module pose_history_ring_cursor_core #(
  parameter int DEPTH       = 32,
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  phrc_in_if.sink    in_i,
  phrc_out_if.source out_o
);
  import phrc_pkg::*;

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CW     = COORD_WIDTH;

  logic              accept;
  logic              we;
  logic [SLOT_W-1:0] waddr, raddr;
  res_t              res_d, res_q;
  logic              out_valid_q;

  logic signed [CW-1:0] wr_x, wr_y, wr_b;
  logic signed [CW-1:0] rd_x, rd_y, rd_b;
  logic [3*CW-1:0]      rdata;
  logic signed [31:0]   add_x_q, add_y_q, add_b_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  phrc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (mode_e'(in_i.mode)),
    .we_o     (we),
    .waddr_o  (waddr),
    .raddr_o  (raddr),
    .res_o    (res_d)
  );

  assign wr_x = CW'(in_i.pose_x);
  assign wr_y = CW'(in_i.pose_y);
  assign wr_b = CW'(in_i.pose_bearing);

  phrc_ram #(.WIDTH(3 * CW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({wr_b, wr_y, wr_x}),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[CW-1:0];
  assign rd_y = rdata[2*CW-1:CW];
  assign rd_b = rdata[3*CW-1:2*CW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        res_q       <= res_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // add words bypass the RAM
  always_ff @(posedge clk_i) begin
    if (accept) begin
      add_x_q <= 32'(wr_x);
      add_y_q <= 32'(wr_y);
      add_b_q <= 32'(wr_b);
    end
  end

  always_comb begin
    out_o.valid      = out_valid_q;
    out_o.moved      = res_q.moved;
    out_o.pose_valid = res_q.pose_valid;
    if (!res_q.pose_valid) begin
      out_o.out_x       = '0;
      out_o.out_y       = '0;
      out_o.out_bearing = '0;
    end else if (res_q.from_add) begin
      out_o.out_x       = add_x_q;
      out_o.out_y       = add_y_q;
      out_o.out_bearing = add_b_q;
    end else begin
      out_o.out_x       = 32'(rd_x);
      out_o.out_y       = 32'(rd_y);
      out_o.out_bearing = 32'(rd_b);
    end
  end

endmodule

[design/phrc_chk.sv]
// ----------------------------------------------------------------------------
// phrc_chk: port-level checks for the pose history ring
// Watches both channels of the core; bound to the top level below.
// ----------------------------------------------------------------------------
module phrc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_mode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_moved_i,
  input logic        out_pose_valid_i,
  input logic [31:0] out_x_i,
  input logic [31:0] out_y_i,
  input logic [31:0] out_bearing_i
);
  import phrc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i) && $stable(out_y_i)
      && $stable(out_bearing_i) && $stable(out_moved_i))
    else $error("result word changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_pose_valid_i |->
      out_x_i == '0 && out_y_i == '0 && out_bearing_i == '0)
    else $error("pose fields nonzero without a pose");

  a_clear_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i == MODE_CLEAR |=> out_valid_i && out_moved_i && !out_pose_valid_i)
    else $error("clear gave wrong result");

  a_add_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_mode_i == MODE_ADD |=> out_valid_i && out_moved_i && out_pose_valid_i)
    else $error("add gave wrong result");

endmodule

bind pose_history_ring_cursor_core phrc_chk u_phrc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_mode_i        (in_i.mode),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_moved_i      (out_o.moved),
  .out_pose_valid_i (out_o.pose_valid),
  .out_x_i          (out_o.out_x),
  .out_y_i          (out_o.out_y),
  .out_bearing_i    (out_o.out_bearing)
);

[bench/pose_history_ring_cursor_core_test.sv]
// ----------------------------------------------------------------------------
// pose_history_ring_cursor_core_test: self-checking bench for the pose ring
// Drives add, step and clear commands over the input channel, predicts each
// result word with a shadow copy of the ring and cursor, and compares every
// accepted output word field by field. Runs a directed opening, then random
// add bursts, cursor walks and mixed traffic under several idle and stall
// mixes, including one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
package phrc_bench_pkg;
  import phrc_pkg::*;

  localparam int RING_DEPTH = 32;

  typedef struct packed {
    mode_e              mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] bearing;
  } pose_cmd_t;

  typedef struct packed {
    logic               moved;
    logic               pose_valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] bearing;
  } pose_reply_t;

  class pose_ring_tracker;
    logic signed [31:0] ring_x [RING_DEPTH];
    logic signed [31:0] ring_y [RING_DEPTH];
    logic signed [31:0] ring_b [RING_DEPTH];
    int                 wr_slot;
    int                 cur_slot;
    int                 fill;
    pose_reply_t        pending[$];
    int                 errors;

    function new();
      wr_slot  = 0;
      cur_slot = 0;
      fill     = 0;
      errors   = 0;
    endfunction

    function void note_command(pose_cmd_t c);
      pose_reply_t r;
      int          oldest;
      int          pos;
      r = '0;
      case (c.mode)
        MODE_ADD: begin
          ring_x[wr_slot] = c.x;
          ring_y[wr_slot] = c.y;
          ring_b[wr_slot] = c.bearing;
          cur_slot = wr_slot;
          wr_slot  = (wr_slot + 1) % RING_DEPTH;
          if (fill < RING_DEPTH) fill++;
          r.moved      = 1'b1;
          r.pose_valid = 1'b1;
        end
        MODE_CLEAR: begin
          wr_slot  = 0;
          cur_slot = 0;
          fill     = 0;
          r.moved  = 1'b1;
        end
        default: begin
          if (fill != 0) begin
            oldest = (wr_slot + RING_DEPTH - fill) % RING_DEPTH;
            pos    = (cur_slot + RING_DEPTH - oldest) % RING_DEPTH;
            if (c.mode == MODE_PREV && pos > 0) begin
              pos--;
              r.moved = 1'b1;
            end else if (c.mode == MODE_NEXT && pos + 1 < fill) begin
              pos++;
              r.moved = 1'b1;
            end
            cur_slot     = (oldest + pos) % RING_DEPTH;
            r.pose_valid = 1'b1;
          end
        end
      endcase
      if (r.pose_valid) begin
        r.x       = ring_x[cur_slot];
        r.y       = ring_y[cur_slot];
        r.bearing = ring_b[cur_slot];
      end
      pending.push_back(r);
    endfunction

    function void check_reply(pose_reply_t got);
      pose_reply_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("moved", 32'(want.moved), 32'(got.moved));
      compare("pose_valid", 32'(want.pose_valid), 32'(got.pose_valid));
      compare("out_x", want.x, got.x);
      compare("out_y", want.y, got.y);
      compare("out_bearing", want.bearing, got.bearing);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction
  endclass
endpackage

module pose_history_ring_cursor_core_test;
  import phrc_pkg::*;
  import phrc_bench_pkg::*;

  localparam int IDLE_LIMIT      = 1000;
  localparam int HOLD_CYCLES     = 100;
  localparam int ITEMS_PER_PHASE = 170;

  logic             clk_i;
  logic             rst_ni;
  phrc_in_if        in_ch ();
  phrc_out_if       out_ch ();
  pose_ring_tracker tracker;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               hold_armed;
  bit               offering;

  pose_history_ring_cursor_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic pose_cmd_t cmd_of(mode_e m, logic signed [31:0] x,
                                       logic signed [31:0] y, logic signed [31:0] b);
    pose_cmd_t c;
    c.mode    = m;
    c.x       = x;
    c.y       = y;
    c.bearing = b;
    return c;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_cmd_t make_cmd(mode_e m);
    return cmd_of(m, pick_coord(), pick_coord(), pick_coord());
  endfunction

  task automatic send_cmd(input pose_cmd_t c);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= c.mode;
    in_ch.pose_x       <= c.x;
    in_ch.pose_y       <= c.y;
    in_ch.pose_bearing <= c.bearing;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    tracker.note_command(c);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (tracker.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int quota);
    int    done;
    int    kind;
    int    len;
    mode_e m;
    done = 0;
    while (done < quota) begin
      kind = $urandom_range(99);
      len  = 1;
      if (kind < 35) begin
        len = $urandom_range(1, 40);
        repeat (len) send_cmd(make_cmd(MODE_ADD));
      end else if (kind < 55) begin
        len = $urandom_range(1, 35);
        repeat (len) send_cmd(make_cmd(MODE_PREV));
      end else if (kind < 75) begin
        len = $urandom_range(1, 35);
        repeat (len) send_cmd(make_cmd(MODE_NEXT));
      end else if (kind < 97) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          m = ($urandom_range(19) == 0) ? MODE_CLEAR : mode_e'($urandom_range(2));
          send_cmd(make_cmd(m));
        end
      end else begin
        send_cmd(make_cmd(MODE_CLEAR));
      end
      done += len;
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // output monitor and watchdog
  initial begin
    int          quiet;
    pose_reply_t got;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_ch.valid && out_ch.ready) begin
          got.moved      = out_ch.moved;
          got.pose_valid = out_ch.pose_valid;
          got.x          = out_ch.out_x;
          got.y          = out_ch.out_y;
          got.bearing    = out_ch.out_bearing;
          tracker.check_reply(got);
        end
        if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
          quiet = 0;
        end else if (++quiet >= IDLE_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 66, 0, 27};
    stall_tab = '{0, 0, 66, 27};
    tracker   = new();
    rst_ni    = 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_ADD;
    in_ch.pose_x       <= '0;
    in_ch.pose_y       <= '0;
    in_ch.pose_bearing <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b0;
    offering       = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty history, then extremes, walks to both ends and blocked steps
    send_cmd(cmd_of(MODE_NEXT, 0, 0, 0));
    send_cmd(cmd_of(MODE_PREV, -1, -1, -1));
    send_cmd(cmd_of(MODE_CLEAR, 0, 0, 0));
    send_cmd(cmd_of(MODE_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_cmd(cmd_of(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_cmd(cmd_of(MODE_ADD, 0, -1, 1));
    send_cmd(cmd_of(MODE_ADD, -1, 0, 32'h7fff_ffff));
    repeat (4) send_cmd(make_cmd(MODE_PREV));
    repeat (4) send_cmd(make_cmd(MODE_NEXT));
    send_cmd(make_cmd(MODE_CLEAR));
    send_cmd(make_cmd(MODE_NEXT));
    send_cmd(make_cmd(MODE_ADD));
    send_cmd(make_cmd(MODE_PREV));
    send_cmd(make_cmd(MODE_NEXT));
    send_cmd(make_cmd(MODE_CLEAR));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      if (ph == 0) hold_armed = 1'b1;
      run_random(ITEMS_PER_PHASE);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
